// ----- design/dad_pkg.sv -----
// ----------------------------------------------------------------------------
// dad_pkg: shared types and constants of the DSP arithmetic datapath
// Item and state structs, operation codes, shift codes and shift tables.
// ----------------------------------------------------------------------------
package dad_pkg;

  typedef enum logic [1:0] {
    OP_ARITH = 2'd0,
    OP_COND  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NOP   = 2'd3
  } op_e;

  typedef enum logic [3:0] {
    ALU_PASS_A  = 4'd0,
    ALU_NEG_B   = 4'd1,
    ALU_ADD     = 4'd2,
    ALU_ADD_C   = 4'd3,
    ALU_SUB     = 4'd4,
    ALU_SUB_C   = 4'd5,
    ALU_INC     = 4'd6,
    ALU_DEC     = 4'd7,
    ALU_PASS_A2 = 4'd8,
    ALU_NOT     = 4'd9,
    ALU_AND     = 4'd10,
    ALU_NAND    = 4'd11,
    ALU_OR      = 4'd12,
    ALU_NOR     = 4'd13,
    ALU_XOR     = 4'd14,
    ALU_XNOR    = 4'd15
  } alu_op_e;

  typedef enum logic [1:0] {
    SRC_ACC  = 2'd0,
    SRC_ALU1 = 2'd1,
    SRC_ALU2 = 2'd2,
    SRC_MULT = 2'd3
  } src_e;

  // shift codes with a fixed meaning
  localparam logic [7:0] SH_CLIP     = 8'd7;
  localparam logic [7:0] SH_CLIP_ALT = 8'd23;
  localparam logic [7:0] SH_ROT      = 8'd8;
  localparam logic [7:0] SH_ROT_ALT  = 8'd24;

  localparam logic [31:0] ROUND_STEP  = 32'h0000_1000;
  localparam logic [31:0] CLIP_POS    = 32'h7fff_f000;
  localparam logic [31:0] CLIP_NEG    = 32'h8000_0000;
  localparam logic [31:0] ROT_HI_MASK = 32'hfffe_0000;
  localparam logic [31:0] FRAC_MASK   = 32'h0000_f000;
  localparam logic [31:0] CARRY_BIT16 = 32'h0001_0000;

  typedef struct packed {
    logic zero;
    logic negative;
    logic carry;
    logic overflow;
    logic exact;
  } status_t;

  typedef struct packed {
    logic [31:0] acc;
    status_t     flags;
  } state_t;

  typedef struct packed {
    op_e         op;
    alu_op_e     alu_op;
    src_e        mux_a;
    src_e        mux_b;
    logic        mult_select;
    logic [7:0]  shift_code;
    logic [15:0] mult1;
    logic [15:0] mult2;
    logic [15:0] alu1;
    logic [15:0] alu2;
    logic [4:0]  condition;
  } item_t;

  // left shift amount for low shift nibble 1..6
  function automatic logic [3:0] left_amt(input logic [3:0] low);
    logic [3:0] amt;
    unique case (low)
      4'd1:    amt = 4'd1;
      4'd2:    amt = 4'd2;
      4'd3:    amt = 4'd3;
      4'd4:    amt = 4'd4;
      4'd5:    amt = 4'd5;
      4'd6:    amt = 4'd8;
      default: amt = 4'd0;
    endcase
    return amt;
  endfunction

  // right shift amount for low shift nibble 9..15
  function automatic logic [4:0] right_amt(input logic [3:0] low);
    logic [4:0] amt;
    unique case (low)
      4'd9:    amt = 5'd16;
      4'd10:   amt = 5'd8;
      4'd11:   amt = 5'd5;
      4'd12:   amt = 5'd4;
      4'd13:   amt = 5'd3;
      4'd14:   amt = 5'd2;
      4'd15:   amt = 5'd1;
      default: amt = 5'd0;
    endcase
    return amt;
  endfunction

endpackage

// ----- design/dsp_arithmetic_datapath.sv -----
// ----------------------------------------------------------------------------
// dsp_arithmetic_datapath: execute stage of an audio DSP
// Accumulator, status flags, ALU, multiplier, barrel shift and branch test.
// ----------------------------------------------------------------------------
//
//   channel  direction  handshake                  payload
//   in       input      in_valid_i / in_stall_o    op .. condition, one word
//   out      output     out_valid_o / out_stall_i  result .. condition_true
//
// one word is accepted every cycle while the output does not stall; its
// result is registered at the edge at which the word leaves the input register
// the rate is set by the accumulator and flag feedback, which closes
// combinationally through the multiplier, the ALU and the shifter
// reset clears the accumulator, the flags and both valid bits
// a stalled output holds the state; the input register then fills and
// in_stall_o rises, so at most one word waits on each side
//
module dsp_arithmetic_datapath (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  op_i,
  input  logic [3:0]  alu_op_i,
  input  logic [1:0]  mux_a_i,
  input  logic [1:0]  mux_b_i,
  input  logic        mult_select_i,
  input  logic [7:0]  shift_code_i,
  input  logic [15:0] mult1_i,
  input  logic [15:0] mult2_i,
  input  logic [15:0] alu1_i,
  input  logic [15:0] alu2_i,
  input  logic [4:0]  condition_i,
  // output channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] result_o,
  output logic [15:0] writeback_word_o,
  output logic        zero_flag_o,
  output logic        negative_flag_o,
  output logic        carry_flag_o,
  output logic        overflow_flag_o,
  output logic        exact_flag_o,
  output logic        condition_true_o
);
  import dad_pkg::*;

  item_t  item_d;
  item_t  item_q;
  logic   in_valid_q;
  logic   out_valid_q;
  state_t state_d;
  state_t state_q;
  logic   ctrue_d;
  logic   ctrue_q;
  logic   in_take;
  logic   fire;

  // input word as a struct
  assign item_d.op          = op_e'(op_i);
  assign item_d.alu_op      = alu_op_e'(alu_op_i);
  assign item_d.mux_a       = src_e'(mux_a_i);
  assign item_d.mux_b       = src_e'(mux_b_i);
  assign item_d.mult_select = mult_select_i;
  assign item_d.shift_code  = shift_code_i;
  assign item_d.mult1       = mult1_i;
  assign item_d.mult2       = mult2_i;
  assign item_d.alu1        = alu1_i;
  assign item_d.alu2        = alu2_i;
  assign item_d.condition   = condition_i;

  // the registered word executes when the result slot is free or draining
  assign fire       = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !fire;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (fire) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      item_q <= item_d;
    end
  end

  dad_exec u_exec (
    .item_i      (item_q),
    .state_i     (state_q),
    .state_o     (state_d),
    .cond_true_o (ctrue_d)
  );

  // the architectural state doubles as the result register: it only moves
  // when the previous result has been taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      state_q     <= '0;
      ctrue_q     <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
      state_q     <= state_d;
      ctrue_q     <= ctrue_d;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign result_o         = state_q.acc;
  assign writeback_word_o = state_q.acc[31:16];
  assign zero_flag_o      = state_q.flags.zero;
  assign negative_flag_o  = state_q.flags.negative;
  assign carry_flag_o     = state_q.flags.carry;
  assign overflow_flag_o  = state_q.flags.overflow;
  assign exact_flag_o     = state_q.flags.exact;
  assign condition_true_o = ctrue_q;

  // an executed word always shows up as a result
  a_fire_gives_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> out_valid_o)
    else $error("executed word produced no result");

  // state must not move under a stalled result
  a_state_held : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(result_o) && $stable(state_q.flags))
    else $error("state changed while result stalled");

  // only condition words can report a taken branch
  a_cond_only : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && (item_q.op != OP_COND) |=> !condition_true_o)
    else $error("branch outcome set by non-condition word");

  // a clear word leaves zero state
  a_clear : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && (item_q.op == OP_CLEAR) |=> (result_o == '0) && !carry_flag_o
      && !zero_flag_o && !overflow_flag_o && !exact_flag_o && !negative_flag_o)
    else $error("clear word left state behind");

  // an empty input register never pushes back
  a_no_idle_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_valid_q |-> !in_stall_o)
    else $error("stall raised with empty input register");

endmodule

// ----- design/dad_exec.sv -----
// ----------------------------------------------------------------------------
// dad_exec: execute logic of the DSP arithmetic datapath
// Operand select, multiplier, ALU, flags, barrel shift and branch condition.
// ----------------------------------------------------------------------------
module dad_exec (
  input  dad_pkg::item_t  item_i,
  input  dad_pkg::state_t state_i,
  output dad_pkg::state_t state_o,
  output logic            cond_true_o
);
  import dad_pkg::*;

  localparam logic [1:0] MODE_NEVER  = 2'd0;
  localparam logic [1:0] MODE_SET    = 2'd1;
  localparam logic [1:0] MODE_CLEAR  = 2'd2;

  function automatic logic carry_of_add(input logic [31:0] a, b, y);
    logic [31:0] t;
    t = (a & b) | (a & ~y) | (b & ~y);
    return t[31];
  endfunction

  function automatic logic carry_of_sub(input logic [31:0] a, b, y);
    logic [31:0] t;
    t = (a & ~b) | (a & ~y) | (~b & ~y);
    return t[31];
  endfunction

  function automatic logic add_ovf(input logic [31:0] a, b, y);
    logic [31:0] t;
    t = (a & b & ~y) | (~a & ~b & y);
    return t[31];
  endfunction

  function automatic logic sub_ovf(input logic [31:0] a, b, y);
    logic [31:0] t;
    t = (a & ~b & ~y) | (~a & b & y);
    return t[31];
  endfunction

  status_t            st;
  logic [31:0]        acc;
  logic [31:0]        m1_ext;
  logic [31:0]        acc_asr;
  logic [31:0]        mul_rhs;
  logic signed [31:0] prod_full;
  logic [31:0]        mul_prod;
  logic [31:0]        mult_a;
  logic [31:0]        mult_b;
  logic               acsbu;
  logic [31:0]        opnd_a;
  logic [31:0]        src_b;
  logic [31:0]        opnd_b;
  logic [31:0]        alu_y;
  logic               alu_c;
  logic               alu_v;
  status_t            new_flags;
  logic [31:0]        shift_y;
  logic [3:0]         sh_low;
  logic               cond_eval;
  logic               m0;
  logic               m1;
  logic               sel;
  logic [1:0]         mode;
  logic               s0;
  logic               s1;
  logic               want;

  assign st  = state_i.flags;
  assign acc = state_i.acc;

  // multiplier: mult1 times mult2, or mult1 times accumulator >> 15
  assign m1_ext    = {{16{item_i.mult1[15]}}, item_i.mult1};
  assign acc_asr   = $unsigned($signed(acc) >>> 15);
  assign mul_rhs   = item_i.mult_select ? {{16{item_i.mult2[15]}}, item_i.mult2} : acc_asr;
  assign prod_full = $signed(item_i.mult1) * $signed(mul_rhs);
  assign mul_prod  = prod_full[31:0];

  assign acsbu = (item_i.alu_op == ALU_ADD_C) || (item_i.alu_op == ALU_SUB_C);

  // m1 * (x & ~1) == m1 * x - m1 * x[0]
  always_comb begin
    if (item_i.mult_select) begin
      mult_a = {mul_prod[30:0], 1'b0};
      mult_b = {mul_prod[30:0], 1'b0};
    end else begin
      if (acsbu) begin
        mult_a = st.carry ? {item_i.mult1, 16'h0000} : '0;
      end else begin
        mult_a = mul_prod - (acc_asr[0] ? m1_ext : '0);
      end
      mult_b = {mul_prod[31:1], 1'b0};
    end
  end

  always_comb begin
    unique case (item_i.mux_a)
      SRC_ACC:  opnd_a = acc;
      SRC_ALU1: opnd_a = {item_i.alu1, 16'h0000};
      SRC_ALU2: opnd_a = {item_i.alu2, 16'h0000};
      SRC_MULT: opnd_a = mult_a;
    endcase
    unique case (item_i.mux_b)
      SRC_ACC:  src_b = acc;
      SRC_ALU1: src_b = {item_i.alu1, 16'h0000};
      SRC_ALU2: src_b = {item_i.alu2, 16'h0000};
      SRC_MULT: src_b = mult_b;
    endcase
  end

  // carry-driven variants take the stored carry at bit 16
  assign opnd_b = acsbu ? (st.carry ? CARRY_BIT16 : '0) : src_b;

  always_comb begin
    alu_c = 1'b0;
    alu_v = 1'b0;
    unique case (item_i.alu_op)
      ALU_PASS_A, ALU_PASS_A2: alu_y = opnd_a;
      ALU_NEG_B: begin
        alu_y = 32'd0 - opnd_b;
        alu_c = carry_of_sub('0, opnd_b, alu_y);
        alu_v = sub_ovf('0, opnd_b, alu_y);
      end
      ALU_ADD, ALU_ADD_C: begin
        alu_y = opnd_a + opnd_b;
        alu_c = carry_of_add(opnd_a, opnd_b, alu_y);
        alu_v = add_ovf(opnd_a, opnd_b, alu_y);
      end
      ALU_SUB, ALU_SUB_C: begin
        alu_y = opnd_a - opnd_b;
        alu_c = carry_of_sub(opnd_a, opnd_b, alu_y);
        alu_v = sub_ovf(opnd_a, opnd_b, alu_y);
      end
      ALU_INC: begin
        alu_y = opnd_a + ROUND_STEP;
        alu_c = carry_of_add(opnd_a, ROUND_STEP, alu_y);
        alu_v = add_ovf(opnd_a, ROUND_STEP, alu_y);
      end
      ALU_DEC: begin
        alu_y = opnd_a - ROUND_STEP;
        alu_c = carry_of_sub(opnd_a, ROUND_STEP, alu_y);
        alu_v = sub_ovf(opnd_a, ROUND_STEP, alu_y);
      end
      ALU_NOT:  alu_y = ~opnd_a;
      ALU_AND:  alu_y = opnd_a & opnd_b;
      ALU_NAND: alu_y = ~(opnd_a & opnd_b);
      ALU_OR:   alu_y = opnd_a | opnd_b;
      ALU_NOR:  alu_y = ~(opnd_a | opnd_b);
      ALU_XOR:  alu_y = opnd_a ^ opnd_b;
      ALU_XNOR: alu_y = ~(opnd_a ^ opnd_b);
    endcase
  end

  // barrel shift; clip looks at the freshly set V and N
  assign sh_low = item_i.shift_code[3:0];

  always_comb begin
    new_flags.zero     = (alu_y[31:16] == 16'h0000);
    new_flags.negative = alu_y[31];
    new_flags.carry    = alu_c;
    new_flags.overflow = alu_v;
    new_flags.exact    = (alu_y[15:12] == 4'h0);
    priority if ((sh_low >= 4'd1) && (sh_low <= 4'd6)) begin
      shift_y = alu_y << left_amt(sh_low);
    end else if ((item_i.shift_code == SH_CLIP) || (item_i.shift_code == SH_CLIP_ALT)) begin
      if (alu_v) begin
        shift_y = new_flags.negative ? CLIP_POS : CLIP_NEG;
      end else begin
        shift_y = alu_y;
      end
    end else if ((item_i.shift_code == SH_ROT) || (item_i.shift_code == SH_ROT_ALT)) begin
      new_flags.carry = alu_y[31];
      shift_y = ({alu_y[30:0], 1'b0} & ROT_HI_MASK) | (alu_y[31] ? CARRY_BIT16 : '0)
              | (alu_y & FRAC_MASK);
    end else if ((item_i.shift_code[7:4] == 4'h0) && (sh_low >= 4'd9)) begin
      shift_y = $unsigned($signed(alu_y) >>> right_amt(sh_low));
    end else if ((item_i.shift_code[7:4] == 4'h1) && (sh_low >= 4'd9)) begin
      shift_y = alu_y >> right_amt(sh_low);
    end else begin
      shift_y = alu_y;
    end
  end

  // branch condition against the stored flags
  assign m0   = item_i.condition[0];
  assign m1   = item_i.condition[1];
  assign sel  = item_i.condition[2];
  assign mode = item_i.condition[4:3];
  assign s0   = sel ? st.carry : st.negative;
  assign s1   = sel ? st.zero : st.overflow;
  assign want = (mode == MODE_SET);

  always_comb begin
    priority if (mode == MODE_NEVER) begin
      cond_eval = 1'b0;
    end else if ((mode == MODE_SET) && !m0 && !m1) begin
      cond_eval = sel ^ (st.zero && st.exact);
    end else if ((mode == MODE_SET) || (mode == MODE_CLEAR)) begin
      cond_eval = (!m1 || (s0 == want)) && (!m0 || (s1 == want));
    end else if (!sel) begin
      cond_eval = ((st.negative != st.overflow) || (st.zero && m0)) != m1;
    end else if (!m1) begin
      cond_eval = (st.carry && !st.zero) != m0;
    end else begin
      cond_eval = st.exact != m0;
    end
  end

  always_comb begin
    cond_true_o = 1'b0;
    unique case (item_i.op)
      OP_ARITH: begin
        state_o.acc   = shift_y;
        state_o.flags = new_flags;
      end
      OP_COND: begin
        state_o     = state_i;
        cond_true_o = cond_eval;
      end
      OP_CLEAR: state_o = '0;
      OP_NOP:   state_o = state_i;
    endcase
  end

endmodule

// ----- test/dad_checker.sv -----
// ----------------------------------------------------------------------------
// dad_checker: result checker for the DSP arithmetic datapath
// Keeps its own copy of the accumulator and status flags, works out the
// outcome of every accepted input word and compares each accepted result
// word, field by field, with the oldest outcome still waiting.
// ----------------------------------------------------------------------------
module dad_checker (
  input  logic           clk_i,
  input  logic           rst_ni,
  // input channel, observed
  input  logic           in_valid_i,
  input  logic           in_stall_i,
  input  dad_pkg::item_t word_i,
  // output channel, observed
  input  logic           out_valid_i,
  input  logic           out_stall_i,
  input  logic [31:0]    result_i,
  input  logic [15:0]    writeback_word_i,
  input  logic           zero_flag_i,
  input  logic           negative_flag_i,
  input  logic           carry_flag_i,
  input  logic           overflow_flag_i,
  input  logic           exact_flag_i,
  input  logic           condition_true_i,
  // verdict
  output int unsigned    error_count_o,
  output int unsigned    pending_count_o
);
  import dad_pkg::*;

  // branch condition modes, bits 4..3 of the condition code
  localparam logic [1:0] COND_NEVER     = 2'd0;
  localparam logic [1:0] COND_ALL_SET   = 2'd1;
  localparam logic [1:0] COND_ALL_CLEAR = 2'd2;

  // shift code ranges
  localparam logic [3:0] LSL_FIRST = 4'd1;
  localparam logic [3:0] LSL_LAST  = 4'd6;
  localparam logic [7:0] ASR_FIRST = 8'd9;
  localparam logic [7:0] ASR_LAST  = 8'd15;
  localparam logic [7:0] LSR_FIRST = 8'd25;
  localparam logic [7:0] LSR_LAST  = 8'd31;

  typedef struct packed {
    logic [31:0] acc;
    status_t     flags;
    logic        taken;
  } outcome_t;

  int unsigned right_dist [7] = '{16, 8, 5, 4, 3, 2, 1};

  logic [31:0] shadow_acc;
  status_t     shadow_flags;
  outcome_t    outcome_q [$];

  function automatic logic [31:0] sext16(input logic [15:0] w);
    return {{16{w[15]}}, w};
  endfunction

  function automatic logic [31:0] asr32(input logic [31:0] v, input int unsigned s);
    return $unsigned($signed(v) >>> s);
  endfunction

  function automatic logic carry_of_add(input logic [31:0] a, input logic [31:0] b,
                                        input logic [31:0] y);
    return (a[31] & b[31]) | (a[31] & ~y[31]) | (b[31] & ~y[31]);
  endfunction

  function automatic logic carry_of_sub(input logic [31:0] a, input logic [31:0] b,
                                        input logic [31:0] y);
    return (a[31] & ~b[31]) | (a[31] & ~y[31]) | (~b[31] & ~y[31]);
  endfunction

  function automatic logic add_ovf(input logic [31:0] a, input logic [31:0] b,
                                   input logic [31:0] y);
    return (a[31] & b[31] & ~y[31]) | (~a[31] & ~b[31] & y[31]);
  endfunction

  function automatic logic sub_ovf(input logic [31:0] a, input logic [31:0] b,
                                   input logic [31:0] y);
    return (a[31] & ~b[31] & ~y[31]) | (~a[31] & b[31] & y[31]);
  endfunction

  // operand from the source mux; the multiplier path differs for A and B
  function automatic logic [31:0] operand(input src_e sel, input item_t w, input logic for_a,
                                          input logic carry_form);
    logic [31:0] m1;
    logic [31:0] v;
    m1 = sext16(w.mult1);
    case (sel)
      SRC_ACC:  v = shadow_acc;
      SRC_ALU1: v = {w.alu1, 16'h0000};
      SRC_ALU2: v = {w.alu2, 16'h0000};
      default: begin
        if (w.mult_select) v = (m1 * sext16(w.mult2)) << 1;
        else if (!for_a) v = (m1 * asr32(shadow_acc, 15)) & ~32'h1;
        else if (carry_form) v = shadow_flags.carry ? {w.mult1, 16'h0000} : 32'h0;
        else v = m1 * (asr32(shadow_acc, 15) & ~32'h1);
      end
    endcase
    return v;
  endfunction

  // returns {carry, overflow, value}
  function automatic logic [33:0] alu(input alu_op_e code, input logic [31:0] a,
                                      input logic [31:0] b);
    logic [31:0] y;
    logic        c;
    logic        v;
    c = 1'b0;
    v = 1'b0;
    case (code)
      ALU_NEG_B: begin
        y = 32'h0 - b;
        c = carry_of_sub(32'h0, b, y);
        v = sub_ovf(32'h0, b, y);
      end
      ALU_ADD, ALU_ADD_C: begin
        y = a + b;
        c = carry_of_add(a, b, y);
        v = add_ovf(a, b, y);
      end
      ALU_SUB, ALU_SUB_C: begin
        y = a - b;
        c = carry_of_sub(a, b, y);
        v = sub_ovf(a, b, y);
      end
      ALU_INC: begin
        y = a + ROUND_STEP;
        c = carry_of_add(a, ROUND_STEP, y);
        v = add_ovf(a, ROUND_STEP, y);
      end
      ALU_DEC: begin
        y = a - ROUND_STEP;
        c = carry_of_sub(a, ROUND_STEP, y);
        v = sub_ovf(a, ROUND_STEP, y);
      end
      ALU_NOT:  y = ~a;
      ALU_AND:  y = a & b;
      ALU_NAND: y = ~(a & b);
      ALU_OR:   y = a | b;
      ALU_NOR:  y = ~(a | b);
      ALU_XOR:  y = a ^ b;
      ALU_XNOR: y = ~(a ^ b);
      default:  y = a;
    endcase
    return {c, v, y};
  endfunction

  // barrel shift; the carry rotate also rewrites the stored carry
  function automatic logic [31:0] barrel(input logic [7:0] code, input logic [31:0] v);
    logic [31:0] r;
    r = v;
    if (code[3:0] >= LSL_FIRST && code[3:0] <= LSL_LAST) begin
      r = (code[3:0] == LSL_LAST) ? v << 8 : v << code[3:0];
    end else if (code == SH_CLIP || code == SH_CLIP_ALT) begin
      if (shadow_flags.overflow) r = shadow_flags.negative ? CLIP_POS : CLIP_NEG;
    end else if (code == SH_ROT || code == SH_ROT_ALT) begin
      shadow_flags.carry = v[31];
      r = ((v << 1) & ROT_HI_MASK) | (v[31] ? CARRY_BIT16 : 32'h0) | (v & FRAC_MASK);
    end else if (code >= ASR_FIRST && code <= ASR_LAST) begin
      r = asr32(v, right_dist[code - ASR_FIRST]);
    end else if (code >= LSR_FIRST && code <= LSR_LAST) begin
      r = v >> right_dist[code - LSR_FIRST];
    end
    return r;
  endfunction

  function automatic logic branch_taken(input logic [4:0] cond);
    logic       m0;
    logic       m1;
    logic       sel;
    logic       want;
    logic       s0;
    logic       s1;
    logic [1:0] mode;
    m0   = cond[0];
    m1   = cond[1];
    sel  = cond[2];
    mode = cond[4:3];
    if (mode == COND_NEVER) return 1'b0;
    if (mode == COND_ALL_SET && !m0 && !m1)
      return sel ^ (shadow_flags.zero & shadow_flags.exact);
    if (mode == COND_ALL_SET || mode == COND_ALL_CLEAR) begin
      want = (mode == COND_ALL_SET);
      s0 = sel ? shadow_flags.carry : shadow_flags.negative;
      s1 = sel ? shadow_flags.zero : shadow_flags.overflow;
      return (!m1 || s0 == want) && (!m0 || s1 == want);
    end
    if (!sel)
      return ((shadow_flags.negative != shadow_flags.overflow) ||
              (shadow_flags.zero && m0)) != m1;
    if (!m1) return (shadow_flags.carry && !shadow_flags.zero) != m0;
    return shadow_flags.exact != m0;
  endfunction

  // advance the shadow state by one word and return what the block must report
  function automatic outcome_t execute_word(input item_t w);
    logic        carry_form;
    logic [31:0] a;
    logic [31:0] b;
    logic [33:0] cvy;
    outcome_t    res;
    res.taken = 1'b0;
    case (w.op)
      OP_ARITH: begin
        carry_form = (w.alu_op == ALU_ADD_C) || (w.alu_op == ALU_SUB_C);
        a = operand(w.mux_a, w, 1'b1, carry_form);
        if (carry_form) b = shadow_flags.carry ? CARRY_BIT16 : 32'h0;
        else b = operand(w.mux_b, w, 1'b0, 1'b0);
        cvy = alu(w.alu_op, a, b);
        shadow_flags.carry    = cvy[33];
        shadow_flags.overflow = cvy[32];
        shadow_flags.zero     = (cvy[31:16] == 16'h0);
        shadow_flags.negative = cvy[31];
        shadow_flags.exact    = (cvy[15:12] == 4'h0);
        shadow_acc = barrel(w.shift_code, cvy[31:0]);
      end
      OP_COND:  res.taken = branch_taken(w.condition);
      OP_CLEAR: begin
        shadow_acc   = '0;
        shadow_flags = '0;
      end
      default: ;
    endcase
    res.acc   = shadow_acc;
    res.flags = shadow_flags;
    return res;
  endfunction

  task automatic flag_failure(input string msg);
    if (error_count_o < 10) $display("%s", msg);
    error_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    outcome_t want;
    if (!rst_ni) begin
      shadow_acc   = '0;
      shadow_flags = '0;
      outcome_q.delete();
      error_count_o   = 0;
      pending_count_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (outcome_q.size() == 0) begin
          flag_failure($sformatf("unexpected result word acc %h", result_i));
        end else begin
          want = outcome_q.pop_front();
          if (result_i !== want.acc || writeback_word_i !== want.acc[31:16] ||
              zero_flag_i !== want.flags.zero || negative_flag_i !== want.flags.negative ||
              carry_flag_i !== want.flags.carry || overflow_flag_i !== want.flags.overflow ||
              exact_flag_i !== want.flags.exact || condition_true_i !== want.taken)
            flag_failure({
              $sformatf("mismatch: want acc %h wb %h zncve %b%b%b%b%b t %b, ",
                        want.acc, want.acc[31:16], want.flags.zero, want.flags.negative,
                        want.flags.carry, want.flags.overflow, want.flags.exact,
                        want.taken),
              $sformatf("got acc %h wb %h zncve %b%b%b%b%b t %b",
                        result_i, writeback_word_i, zero_flag_i, negative_flag_i,
                        carry_flag_i, overflow_flag_i, exact_flag_i, condition_true_i)});
        end
      end
      if (in_valid_i && !in_stall_i) outcome_q.push_back(execute_word(word_i));
      pending_count_o <= outcome_q.size();
    end
  end

endmodule

// ----- test/tb.sv -----
// ----------------------------------------------------------------------------
// tb: testbench for the DSP arithmetic datapath
// Drives a directed set of words and then random words through the input
// channel under changing sender gaps and receiver stalls; a checker beside
// the block predicts and compares every result word.
// ----------------------------------------------------------------------------
module tb;
  import dad_pkg::*;

  // generous bound on the whole run, far above the slowest legal run
  localparam int unsigned CYCLE_LIMIT      = 200_000;
  localparam int unsigned RANDOM_PER_PHASE = 170;
  localparam int unsigned HOLD_OFF_CYCLES  = 60;
  // drain wait after the last result, to catch stray result words
  localparam int unsigned DRAIN_CYCLES     = 8;

  // shift codes used by the directed words
  localparam logic [7:0] SH_NONE  = 8'd0;
  localparam logic [7:0] SH_LSL1  = 8'd1;
  localparam logic [7:0] SH_LSL8  = 8'd6;
  localparam logic [7:0] SH_ASR16 = 8'd9;
  localparam logic [7:0] SH_ASR1  = 8'd15;
  localparam logic [7:0] SH_LSR16 = 8'd25;
  localparam logic [7:0] SH_LSR1  = 8'd31;
  localparam logic [7:0] SH_TOP   = 8'hff;

  logic        clk;
  logic        rst_ni;
  logic        in_valid;
  logic        in_stall;
  item_t       word;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] result;
  logic [15:0] writeback_word;
  logic        zero_flag;
  logic        negative_flag;
  logic        carry_flag;
  logic        overflow_flag;
  logic        exact_flag;
  logic        condition_true;

  int unsigned errors;
  int unsigned pending;
  int unsigned cycles         = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_off_left  = 0;

  dsp_arithmetic_datapath uut (
    .clk_i            (clk),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .op_i             (word.op),
    .alu_op_i         (word.alu_op),
    .mux_a_i          (word.mux_a),
    .mux_b_i          (word.mux_b),
    .mult_select_i    (word.mult_select),
    .shift_code_i     (word.shift_code),
    .mult1_i          (word.mult1),
    .mult2_i          (word.mult2),
    .alu1_i           (word.alu1),
    .alu2_i           (word.alu2),
    .condition_i      (word.condition),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .result_o         (result),
    .writeback_word_o (writeback_word),
    .zero_flag_o      (zero_flag),
    .negative_flag_o  (negative_flag),
    .carry_flag_o     (carry_flag),
    .overflow_flag_o  (overflow_flag),
    .exact_flag_o     (exact_flag),
    .condition_true_o (condition_true)
  );

  dad_checker result_check (
    .clk_i            (clk),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .word_i           (word),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .result_i         (result),
    .writeback_word_i (writeback_word),
    .zero_flag_i      (zero_flag),
    .negative_flag_i  (negative_flag),
    .carry_flag_i     (carry_flag),
    .overflow_flag_i  (overflow_flag),
    .exact_flag_i     (exact_flag),
    .condition_true_i (condition_true),
    .error_count_o    (errors),
    .pending_count_o  (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run length guard
  always @(posedge clk) begin
    cycles <= cycles + 1;
  end

  initial begin
    wait (cycles == CYCLE_LIMIT);
    $display("DONE: errors detected");
    $finish;
  end

  // receiver: a long hold-off when asked, otherwise random stalls
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_left > 0) begin
        out_stall = 1'b1;
        hold_off_left--;
      end else begin
        out_stall = ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  // offer one word, with random idle cycles first; valid stays high afterwards
  // so back-to-back words see no bubble
  task automatic send_word(input item_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    word     = w;
    in_valid = 1'b1;
    // stall is stable from the falling edge on; read it at the rising edge
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  function automatic item_t arith_word(input alu_op_e alu, input src_e a, input src_e b,
                                       input logic msel, input logic [7:0] sh,
                                       input logic [15:0] x1, input logic [15:0] x2);
    item_t w;
    w = '0;
    w.op          = OP_ARITH;
    w.alu_op      = alu;
    w.mux_a       = a;
    w.mux_b       = b;
    w.mult_select = msel;
    w.shift_code  = sh;
    w.mult1       = x1;
    w.mult2       = x2;
    w.alu1        = x1;
    w.alu2        = x2;
    return w;
  endfunction

  function automatic item_t ctrl_word(input op_e op, input logic [4:0] cond);
    item_t w;
    w = '0;
    w.op        = op;
    w.condition = cond;
    return w;
  endfunction

  // operand words lean toward the sign and range extremes
  function automatic logic [15:0] operand_word();
    case ($urandom_range(7))
      0:       return 16'h0000;
      1:       return 16'hffff;
      2:       return 16'h7fff;
      3:       return 16'h8000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic item_t random_word();
    item_t       w;
    int unsigned pick;
    pick = $urandom_range(99);
    // mostly arithmetic so the flags move, a steady share of branch tests,
    // and now and then a clear to restart the accumulator
    if (pick < 62) w.op = OP_ARITH;
    else if (pick < 87) w.op = OP_COND;
    else if (pick < 95) w.op = OP_NOP;
    else w.op = OP_CLEAR;
    w.alu_op      = alu_op_e'($urandom_range(15));
    w.mux_a       = src_e'($urandom_range(3));
    w.mux_b       = src_e'($urandom_range(3));
    w.mult_select = 1'($urandom_range(1));
    // meaningful shift codes sit in 0..31; the rest only repeat left shifts or pass the value through
    w.shift_code  = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(31));
    w.mult1       = operand_word();
    w.mult2       = operand_word();
    w.alu1        = operand_word();
    w.alu2        = operand_word();
    w.condition   = 5'($urandom_range(31));
    return w;
  endfunction

  task automatic run_phase(input int unsigned idle_pct, input int unsigned stall_pct);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (RANDOM_PER_PHASE) send_word(random_word());
    // sender pause: let every outstanding result word come back
    in_valid = 1'b0;
    wait (pending == 0);
    @(negedge clk);
  endtask

  initial begin
    rst_ni   = 1'b0;
    in_valid = 1'b0;
    word     = '0;
    repeat (5) @(negedge clk);
    rst_ni = 1'b1;
    @(negedge clk);

    // directed words: every alu operation, shift kinds and flag corners
    send_word(ctrl_word(OP_CLEAR, '0));
    // top half all ones through the accumulator
    send_word(arith_word(ALU_PASS_A, SRC_ALU1, SRC_ACC, 1'b1, SH_NONE, 16'hffff, 16'h0000));
    // negating the most negative value overflows
    send_word(arith_word(ALU_NEG_B, SRC_ACC, SRC_ALU2, 1'b1, SH_NONE, 16'h0000, 16'h8000));
    // positive overflow, negative result: clip to the positive limit
    send_word(arith_word(ALU_ADD, SRC_ALU1, SRC_ALU2, 1'b1, SH_CLIP, 16'h7fff, 16'h0001));
    // rounding step on the clipped value overflows again
    send_word(arith_word(ALU_INC, SRC_ACC, SRC_ACC, 1'b1, SH_ASR1, 16'h0000, 16'h0000));
    // negative overflow: clip to the negative limit with the alternate code
    send_word(arith_word(ALU_SUB, SRC_ALU1, SRC_ALU2, 1'b1, SH_CLIP_ALT, 16'h8000, 16'h0001));
    send_word(arith_word(ALU_DEC, SRC_ALU1, SRC_ACC, 1'b1, SH_ROT_ALT, 16'h8000, 16'h0000));
    // carry out of the add, then carry rotate of the upper half
    send_word(arith_word(ALU_ADD, SRC_ALU1, SRC_ALU2, 1'b1, SH_ROT, 16'hffff, 16'hffff));
    // carry forms with the multiplier as A
    send_word(arith_word(ALU_ADD_C, SRC_MULT, SRC_ACC, 1'b0, SH_NONE, 16'h8000, 16'h0000));
    send_word(arith_word(ALU_SUB_C, SRC_MULT, SRC_ACC, 1'b0, SH_LSL1, 16'hffff, 16'h0000));
    // most negative squared, doubled: the product wraps to the sign bit
    send_word(arith_word(ALU_PASS_A2, SRC_MULT, SRC_ACC, 1'b1, SH_ASR16, 16'h8000, 16'h8000));
    send_word(arith_word(ALU_NOT, SRC_ACC, SRC_ACC, 1'b1, SH_LSR16, 16'h0000, 16'h0000));
    // multiplier against the accumulator as B and as A
    send_word(arith_word(ALU_AND, SRC_ALU1, SRC_MULT, 1'b0, SH_LSL8, 16'h7fff, 16'h0000));
    send_word(arith_word(ALU_NAND, SRC_MULT, SRC_ALU2, 1'b0, SH_LSR1, 16'h8000, 16'hffff));
    send_word(arith_word(ALU_OR, SRC_ALU1, SRC_ALU2, 1'b1, SH_TOP, 16'h0f0f, 16'hf0f0));
    send_word(arith_word(ALU_NOR, SRC_ACC, SRC_ALU1, 1'b1, SH_LSL1, 16'h0000, 16'h0000));
    send_word(arith_word(ALU_XOR, SRC_ALU2, SRC_ACC, 1'b1, SH_ASR16, 16'h5555, 16'haaaa));
    send_word(arith_word(ALU_XNOR, SRC_ALU1, SRC_ALU2, 1'b1, SH_NONE, 16'hffff, 16'h0000));
    // branch tests over every condition mode, never-true mode included
    for (int k = 0; k < 5; k++) send_word(ctrl_word(OP_COND, 5'(k * 7)));
    // unused op leaves everything as it is
    send_word(ctrl_word(OP_NOP, '0));
    send_word(ctrl_word(OP_CLEAR, '0));

    // receiver holds off for a long stretch while words keep coming, so the
    // block fills and stalls its input; the rest of the phase runs flat out
    hold_off_left = HOLD_OFF_CYCLES;
    run_phase(0, 0);
    run_phase(85, 0);
    run_phase(0, 85);
    run_phase(85, 85);

    // drain and give the verdict
    in_valid = 1'b0;
    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
